[src/nmt_pkg.sv]
package nmt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_BITS    = 64;
	localparam int ID_BITS     = 8;

	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W = KEY_BITS + ID_BITS;

	localparam int CMD_W    = 2;
	localparam int NAME_W   = 64;
	localparam int SID_W    = 8;
	localparam int STATUS_W = 2;
	localparam int FID_W    = 8;

	localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP   = 2'd1;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FAIL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   waddr;
		logic [ENTRY_W-1:0] wdata;
		logic               re;
		logic [IDX_W-1:0]   raddr;
	} ram_req_t;

endpackage

[src/nmt_req_if.sv]
interface nmt_req_if import nmt_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [NAME_W-1:0] name_key;
	logic [SID_W-1:0]  sender_id;
	logic              malformed;

	modport source(output valid, command, name_key, sender_id, malformed, input ready);
	modport sink(input valid, command, name_key, sender_id, malformed, output ready);
endinterface

[src/nmt_rsp_if.sv]
interface nmt_rsp_if import nmt_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [FID_W-1:0]    found_id;

	modport source(output valid, status, found_id, input ready);
	modport sink(input valid, status, found_id, output ready);
endinterface

[src/nmt_ram.sv]
module nmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/nmt_ctrl.sv]
module nmt_ctrl import nmt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	nmt_req_if.sink            req,
	nmt_rsp_if.source          rsp,
	output ram_req_t           ram_req,
	input  logic [ENTRY_W-1:0] ram_rdata
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_WRITE  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t               state_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [ID_BITS-1:0]   sid_q;
	logic [CNT_W-1:0]     used_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic                 issue_q;
	logic                 cmp_vld_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	logic                 cmp_last_s1;
	logic [IDX_W-1:0]     wr_idx_q;
	logic                 append_q;
	logic [STATUS_W-1:0]  status_q;
	logic [FID_W-1:0]     fid_q;
	logic                 out_vld_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [FID_W-1:0]     out_fid_q;

	logic hit;
	logic full;
	logic out_free;
	logic out_load;
	logic issue_last;
	logic known_cmd;

	always_comb begin
		hit        = cmp_vld_s1 && (ram_rdata[ENTRY_W-1 -: KEY_BITS] == key_q);
		full       = (used_q == CNT_W'(TABLE_DEPTH));
		out_free   = !out_vld_q || rsp.ready;
		out_load   = (state_q == S_FINISH) && out_free;
		issue_last = (CNT_W'(rd_idx_q) == used_q - CNT_W'(1));
		known_cmd  = req.command inside {CMD_REGISTER, CMD_LOOKUP};
	end

	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid    = out_vld_q;
	assign rsp.status   = out_status_q;
	assign rsp.found_id = out_fid_q;

	// Only one request is in flight, so a write always lands before the next search reads.
	always_comb begin
		ram_req.re    = issue_q;
		ram_req.raddr = rd_idx_q;
		ram_req.we    = (state_q == S_WRITE);
		ram_req.waddr = wr_idx_q;
		ram_req.wdata = {key_q, sid_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			issue_q    <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			// One read is issued per cycle; its data is compared in the following cycle.
			// A match stops further reads.
			cmp_vld_s1  <= issue_q;
			cmp_idx_s1  <= rd_idx_q;
			cmp_last_s1 <= issue_last;
			if (issue_q) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
				if (issue_last || hit) begin
					issue_q <= 1'b0;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q    <= req.command;
						key_q    <= req.name_key[KEY_BITS-1:0];
						sid_q    <= req.sender_id[ID_BITS-1:0];
						fid_q    <= '0;
						status_q <= ST_FAIL;
						append_q <= 1'b0;
						if (!req.malformed && known_cmd) begin
							if (used_q == '0) begin
								if (req.command == CMD_REGISTER) begin
									wr_idx_q <= '0;
									append_q <= 1'b1;
									status_q <= ST_OK;
									state_q  <= S_WRITE;
								end else begin
									state_q <= S_FINISH;
								end
							end else begin
								rd_idx_q <= '0;
								issue_q  <= 1'b1;
								state_q  <= S_SCAN;
							end
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						status_q <= ST_OK;
						if (cmd_q == CMD_REGISTER) begin
							wr_idx_q <= cmp_idx_s1;
							append_q <= 1'b0;
							state_q  <= S_WRITE;
						end else begin
							fid_q   <= FID_W'(ram_rdata[ID_BITS-1:0]);
							state_q <= S_FINISH;
						end
					end else if (cmp_vld_s1 && cmp_last_s1) begin
						if (cmd_q == CMD_REGISTER) begin
							if (full) begin
								status_q <= ST_FULL;
								state_q  <= S_FINISH;
							end else begin
								wr_idx_q <= used_q[IDX_W-1:0];
								append_q <= 1'b1;
								status_q <= ST_OK;
								state_q  <= S_WRITE;
							end
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_WRITE: begin
					if (append_q) begin
						used_q <= used_q + CNT_W'(1);
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						out_status_q <= status_q;
						out_fid_q    <= fid_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	a_used_steps: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(used_q) |-> (used_q == $past(used_q) + CNT_W'(1)))
		else $error("entry count changed by other than one");

	a_write_is_register: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> (cmd_q == CMD_REGISTER))
		else $error("table written by a request that is not a register");

	a_append_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && append_q) |-> !full)
		else $error("append into a full table");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && status_q == ST_FULL) |-> full)
		else $error("table-full status while entries remain");
`endif

endmodule

[src/name_to_id_table.sv]
// Name to task id table.
// The req channel carries one request per transfer: a command (register or look up),
// a name key, the sender's task id and a malformed flag. The rsp channel returns one
// result per request: a status (success, failure or table full) and the bound id.
// A request searches the entries in use with one memory read per cycle; at most 64
// entries are in use. A look up stops at the first matching entry or after the last
// entry in use. A register adds the table write after its search, except a new key
// into a full table, which is refused. Malformed or unknown requests and look ups in
// an empty table skip the search, and a register into an empty table goes straight to
// the write. The entry memory has a single read port, and one request is handled at a
// time.
// A new request is taken as soon as the previous result sits in the output register,
// even if the receiver has not yet taken it. While the receiver stalls, the next
// request runs up to its result and then waits for the output register to free.
// Reset empties the table at once by clearing the entry count; the memory itself is
// not swept, and entries at or above the count are never read.
module name_to_id_table import nmt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	nmt_req_if.sink   req,
	nmt_rsp_if.source rsp
);

	ram_req_t           ram_req;
	logic [ENTRY_W-1:0] ram_rdata;

	nmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	nmt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_entries (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

[tb/tb_name_to_id_table.sv]
module tb_name_to_id_table;
	import nmt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN_A = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN_B = 2'd3;

	localparam int NUM_RANDOM     = 1880;
	localparam int CALM_TAIL      = 300;
	localparam int POOL_SIZE      = 160;
	localparam int NARROW_SPAN    = 40;
	localparam int NARROW_ITEMS   = 700;
	localparam int DRAIN_CYCLES   = 80;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FID_W-1:0]    found_id;
	} reply_t;

	// Mirror of the name table; works out the reply to each request and keeps
	// the replies still owed by the block in order.
	class name_table_model;
		logic [KEY_BITS-1:0] names [TABLE_DEPTH];
		logic [ID_BITS-1:0]  ids [TABLE_DEPTH];
		int                  used;
		reply_t              pending_replies [$];
		int                  errors;

		function new();
			used   = 0;
			errors = 0;
		endfunction

		function void note_request(logic [CMD_W-1:0] cmd, logic [NAME_W-1:0] key,
				logic [SID_W-1:0] sid, logic bad);
			reply_t r;
			int     hit;
			r.status   = ST_FAIL;
			r.found_id = '0;
			hit        = -1;
			for (int i = 0; i < used; i++) begin
				if (hit < 0 && names[i] == key[KEY_BITS-1:0])
					hit = i;
			end
			if (!bad && cmd == CMD_REGISTER) begin
				if (hit >= 0) begin
					ids[hit] = sid[ID_BITS-1:0];
					r.status = ST_OK;
				end else if (used < TABLE_DEPTH) begin
					names[used] = key[KEY_BITS-1:0];
					ids[used]   = sid[ID_BITS-1:0];
					used++;
					r.status = ST_OK;
				end else begin
					r.status = ST_FULL;
				end
			end else if (!bad && cmd == CMD_LOOKUP && hit >= 0) begin
				r.status   = ST_OK;
				r.found_id = ids[hit];
			end
			pending_replies.push_back(r);
		endfunction

		function void check_reply(logic [STATUS_W-1:0] status, logic [FID_W-1:0] found_id);
			reply_t want;
			if (pending_replies.size() == 0) begin
				$error("reply with no request outstanding: status %0d found_id %0d",
					status, found_id);
				errors++;
				return;
			end
			want = pending_replies.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				errors++;
			end
			if (found_id !== want.found_id) begin
				$error("found_id: expected %0d, got %0d", want.found_id, found_id);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	nmt_req_if req();
	nmt_rsp_if rsp();

	name_to_id_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	name_table_model  table_model = new();
	int               idle_pct;
	int               quiet_cycles = 0;
	logic [NAME_W-1:0] key_pool [POOL_SIZE];

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Monitor and watchdog. The reply is checked before the request of the same
	// edge is noted, as a reply always belongs to an earlier request.
	always @(posedge clk) begin
		if (rsp.valid && rsp.ready)
			table_model.check_reply(rsp.status, rsp.found_id);
		if (req.valid && req.ready)
			table_model.note_request(req.command, req.name_key, req.sender_id, req.malformed);
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_name_to_id_table: FAIL");
			$finish;
		end
	end

	// Receiver: holds ready low in bursts of random length.
	initial begin
		int hold;
		hold = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold == 0 && $urandom_range(0, 99) < idle_pct)
				hold = $urandom_range(1, 6);
			if (hold > 0) begin
				rsp.ready <= 1'b0;
				hold--;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	function automatic logic [NAME_W-1:0] random_key();
		return {$urandom(), $urandom()};
	endfunction

	// Presents one request and returns once it has been transferred.
	task automatic issue(logic [CMD_W-1:0] cmd, logic [NAME_W-1:0] key,
			logic [SID_W-1:0] sid, logic bad);
		if ($urandom_range(0, 99) < idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.command   <= cmd;
		req.name_key  <= key;
		req.sender_id <= sid;
		req.malformed <= bad;
		do @(posedge clk); while (!req.ready);
	endtask

	initial begin
		logic [CMD_W-1:0]  cmd;
		logic [NAME_W-1:0] key;
		int                sel;
		int                span;

		idle_pct       = 20;
		arst_n        <= 1'b0;
		req.valid     <= 1'b0;
		req.command   <= CMD_REGISTER;
		req.name_key  <= '0;
		req.sender_id <= '0;
		req.malformed <= 1'b0;

		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = random_key();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: empty table, extreme keys and ids, re-binding, misses,
		// malformed requests and unknown commands.
		issue(CMD_LOOKUP,    '0, 8'd0, 1'b0);
		issue(CMD_REGISTER,  '0, 8'd0, 1'b0);
		issue(CMD_REGISTER,  '1, 8'hFF, 1'b0);
		issue(CMD_LOOKUP,    '0, 8'd7, 1'b0);
		issue(CMD_LOOKUP,    '1, 8'd0, 1'b0);
		issue(CMD_REGISTER,  '1, 8'h5A, 1'b0);
		issue(CMD_LOOKUP,    '1, 8'h00, 1'b0);
		issue(CMD_LOOKUP,    64'h1, 8'h00, 1'b0);
		issue(CMD_REGISTER,  64'h1234_5678_9ABC_DEF0, 8'h11, 1'b1);
		issue(CMD_LOOKUP,    64'h1234_5678_9ABC_DEF0, 8'h00, 1'b0);
		issue(CMD_LOOKUP,    '0, 8'h00, 1'b1);
		issue(CMD_REGISTER,  '1, 8'h33, 1'b1);
		issue(CMD_LOOKUP,    '1, 8'h00, 1'b0);
		issue(CMD_UNKNOWN_A, '0, 8'hFF, 1'b0);
		issue(CMD_UNKNOWN_B, '1, 8'hFF, 1'b0);
		issue(CMD_UNKNOWN_B, '1, 8'hFF, 1'b1);
		issue(CMD_REGISTER,  64'h8000_0000_0000_0000, 8'h80, 1'b0);
		issue(CMD_REGISTER,  64'h5555_5555_5555_5555, 8'h55, 1'b0);
		issue(CMD_REGISTER,  64'hAAAA_AAAA_AAAA_AAAA, 8'hAA, 1'b0);
		issue(CMD_LOOKUP,    64'h8000_0000_0000_0000, 8'h00, 1'b0);
		issue(CMD_LOOKUP,    64'h5555_5555_5555_5555, 8'h00, 1'b0);
		issue(CMD_LOOKUP,    64'hAAAA_AAAA_AAAA_AAAA, 8'h00, 1'b0);
		issue(CMD_LOOKUP,    64'h0000_0000_0000_0001, 8'h00, 1'b0);

		// Random part. A narrow key pool first keeps the table partly filled with
		// many hits; the wide pool then fills it, after which new keys are refused.
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n >= NUM_RANDOM - CALM_TAIL)
				idle_pct = 0;
			else if (n % 100 == 0)
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 12;
					default: idle_pct = 40;
				endcase
			span = (n < NARROW_ITEMS) ? NARROW_SPAN : POOL_SIZE;
			sel  = $urandom_range(0, 99);
			if (sel < 3)
				cmd = CMD_UNKNOWN_A;
			else if (sel < 6)
				cmd = CMD_UNKNOWN_B;
			else if (sel < 53)
				cmd = CMD_REGISTER;
			else
				cmd = CMD_LOOKUP;
			if ($urandom_range(0, 99) < 4)
				key = random_key();
			else
				key = key_pool[$urandom_range(0, span - 1)];
			issue(cmd, key, SID_W'($urandom_range(0, 255)), $urandom_range(0, 99) < 6);
		end
		req.valid <= 1'b0;

		while (table_model.pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (table_model.errors == 0 && table_model.pending_replies.size() == 0)
			$display("tb_name_to_id_table: PASS");
		else
			$display("tb_name_to_id_table: FAIL");
		$finish;
	end

endmodule
